### hw/rtl/mi4_pkg.sv
package mi4_pkg;

  localparam int EL_W  = 32;
  localparam int IDX_W = 4;

  localparam logic [EL_W-1:0] EL_MAX = 32'h7FFF_FFFF;
  localparam logic [EL_W-1:0] EL_MIN = 32'h8000_0000;

  // Permutation code 0..5 over the three columns of a 3x3 minor
  typedef logic [2:0] perm_t;
  localparam perm_t PERM_LAST = 3'd5;

  // n-th of the three indexes 0..3 that are left once drop is removed
  function automatic logic [1:0] skip_sel(input logic [1:0] drop, input logic [1:0] n);
    return (n < drop) ? n : n + 2'd1;
  endfunction

  // Column picked for minor row n by permutation p
  function automatic logic [1:0] perm_col(input perm_t p, input logic [1:0] n);
    logic [5:0] cols;
    case (p)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd1, 2'd2, 2'd0};
      3'd2:    cols = {2'd2, 2'd0, 2'd1};
      3'd3:    cols = {2'd0, 2'd2, 2'd1};
      3'd4:    cols = {2'd1, 2'd0, 2'd2};
      default: cols = {2'd0, 2'd1, 2'd2};
    endcase
    case (n)
      2'd0:    return cols[1:0];
      2'd1:    return cols[3:2];
      default: return cols[5:4];
    endcase
  endfunction

  // Odd permutations carry a minus sign
  function automatic logic perm_odd(input perm_t p);
    return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  endfunction

endpackage

### hw/rtl/mi4_if.sv
interface mi4_in_if;
  import mi4_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [EL_W-1:0] element;
  modport source(output valid, output element, input ready);
  modport sink(input valid, input element, output ready);
endinterface

interface mi4_out_if;
  import mi4_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [EL_W-1:0] inverse_element;
  logic [IDX_W-1:0]       element_index;
  logic                   last;
  logic                   singular;
  logic                   saturated;
  modport source(output valid, output inverse_element, output element_index,
                 output last, output singular, output saturated, input ready);
  modport sink(input valid, input inverse_element, input element_index,
               input last, input singular, input saturated, output ready);
endinterface

### hw/rtl/mi4_mul.sv
// Shift-add multiplier: wide signed operand times 32-bit signed operand.
// One partial product bit per cycle, then a sign fixup step.
module mi4_mul #(
  parameter int W = 131
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [W-1:0]             a,
  input  logic [mi4_pkg::EL_W-1:0] b,
  output logic                     done,
  output logic [W-1:0]             p
);
  import mi4_pkg::*;

  logic [W-1:0]    a_sh_r;
  logic [W-1:0]    acc_r;
  logic [EL_W-1:0] b_r;
  logic [4:0]      cnt_r;
  logic            neg_r;
  logic            run_r;
  logic            fin_r;
  logic            done_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: magnitudes in, sign applied at the end
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= a[W-1] ? (~a + 1'b1) : a;
      b_r    <= b[EL_W-1] ? (~b + 1'b1) : b;
      neg_r  <= a[W-1] ^ b[EL_W-1];
      acc_r  <= '0;
    end else if (run_r) begin
      if (b_r[0]) acc_r <= acc_r + a_sh_r;
      a_sh_r <= {a_sh_r[W-2:0], 1'b0};
      b_r    <= {1'b0, b_r[EL_W-1:1]};
    end else if (fin_r) begin
      if (neg_r) acc_r <= ~acc_r + 1'b1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

### hw/rtl/mi4_div.sv
// Restoring divider on unsigned magnitudes, one quotient bit per cycle.
module mi4_div #(
  parameter int W = 131
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W);

  logic [W:0]    rem_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  d_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_sub;
  logic          fits;

  // one trial subtract per step
  always_comb begin
    rem_sh  = {rem_r[W-1:0], q_r[W-1]};
    rem_sub = rem_sh - {1'b0, d_r};
    fits    = rem_sh >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      d_r   <= den;
    end else if (run_r) begin
      rem_r <= fits ? rem_sub : rem_sh;
      q_r   <= {q_r[W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

### hw/rtl/matrix_inverse_4x4.sv
// 4x4 matrix inverse by cofactors, signed fixed point with FRAC_BITS
// fraction bits (Q16.16 by default).
// in_chan: one matrix element per word, row-major; the sixteenth word of a
//   matrix starts the inverse. Input is taken only while loading.
// out_chan: sixteen words of the inverse, row-major, with element_index,
//   last on the final word, singular on a zero determinant (all words then
//   read 0x7FFFFFFF) and saturated when a word was clipped to 32 bits.
// Steps: each of the 96 cofactor terms takes three matrix reads and two
//   passes through the shift-add multiplier, the determinant four more
//   multiplier passes, and each output word a pass through the W-bit
//   one-bit-a-step divider (W = 131 at the default FRAC_BITS).
// Cofactors are kept in a 16-entry memory; matrix elements in another.
// A stalled receiver holds the current output word; nothing else moves.
// Reset returns the block to loading the first element of a new matrix.
module matrix_inverse_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mi4_in_if.sink     in_chan,
  mi4_out_if.source  out_chan
);
  import mi4_pkg::*;

  localparam int W = (2 * FRAC_BITS + 97 > 131) ? 2 * FRAC_BITS + 97 : 131;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_TA   = 4'd1;
  localparam logic [3:0] S_TB   = 4'd2;
  localparam logic [3:0] S_TC   = 4'd3;
  localparam logic [3:0] S_TD   = 4'd4;
  localparam logic [3:0] S_TM1  = 4'd5;
  localparam logic [3:0] S_TM2  = 4'd6;
  localparam logic [3:0] S_DA   = 4'd7;
  localparam logic [3:0] S_DB   = 4'd8;
  localparam logic [3:0] S_DM   = 4'd9;
  localparam logic [3:0] S_DCHK = 4'd10;
  localparam logic [3:0] S_VA   = 4'd11;
  localparam logic [3:0] S_VB   = 4'd12;
  localparam logic [3:0] S_VDIV = 4'd13;
  localparam logic [3:0] S_VOUT = 4'd14;

  logic [3:0]       state_r;
  logic [3:0]       load_cnt_r;
  logic [3:0]       cof_idx_r;
  perm_t            perm_r;
  logic [1:0]       dj_r;
  logic [3:0]       vk_r;
  logic [W-1:0]     acc_r;
  logic [W-1:0]     det_r;
  logic [W-1:0]     dmag_r;
  logic             dneg_r;
  logic             sing_r;
  logic             num_neg_r;
  logic [EL_W-1:0]  el_a_r;
  logic [EL_W-1:0]  el_b_r;
  logic [EL_W-1:0]  el_c_r;
  logic [EL_W-1:0]  out_val_r;
  logic             out_sat_r;

  // memories
  logic [EL_W-1:0]  mat_mem [16];
  logic [W-1:0]     cof_mem [16];
  logic [EL_W-1:0]  mat_rd_r;
  logic [W-1:0]     cof_rd_r;
  logic [3:0]       mat_addr;
  logic [3:0]       cof_addr;

  // arithmetic units
  logic             mul_start;
  logic [W-1:0]     mul_a;
  logic [EL_W-1:0]  mul_b;
  logic             mul_done;
  logic [W-1:0]     mul_p;
  logic             div_start;
  logic [W-1:0]     div_num;
  logic             div_done;
  logic [W-1:0]     div_q;

  logic             in_fire;
  logic [1:0]       ci;
  logic [1:0]       cj;
  logic [1:0]       term_row;
  logic             term_neg;
  logic [W-1:0]     term_sum;
  logic [W-1:0]     cof_abs;
  logic             q_neg;
  logic [EL_W-1:0]  q_lim;
  logic             q_sat;
  logic [EL_W-1:0]  q_val;

  assign in_fire = in_chan.valid && in_chan.ready;
  assign ci      = cof_idx_r[3:2];
  assign cj      = cof_idx_r[1:0];

  // read addresses: minor element, row-0 determinant terms, transposed cofactor for output
  always_comb begin
    case (state_r)
      S_TB:    term_row = 2'd1;
      S_TC:    term_row = 2'd2;
      default: term_row = 2'd0;
    endcase
    if (state_r == S_DA) begin
      mat_addr = {2'd0, dj_r};
    end else begin
      mat_addr = {skip_sel(ci, term_row), skip_sel(cj, perm_col(perm_r, term_row))};
    end
    if (state_r == S_VA) begin
      cof_addr = {vk_r[1:0], vk_r[3:2]};
    end else begin
      cof_addr = {2'd0, dj_r};
    end
  end

  // matrix store: written while loading; read data is registered
  always_ff @(posedge clk) begin
    if (in_fire) mat_mem[load_cnt_r] <= in_chan.element;
    mat_rd_r <= mat_mem[mat_addr];
  end

  // signed term accumulate; sign from permutation parity and (i+j)
  assign term_neg = perm_odd(perm_r) ^ ci[0] ^ cj[0];
  assign term_sum = term_neg ? (acc_r - mul_p) : (acc_r + mul_p);

  // cofactor store
  always_ff @(posedge clk) begin
    if (state_r == S_TM2 && mul_done && perm_r == PERM_LAST) cof_mem[cof_idx_r] <= term_sum;
    cof_rd_r <= cof_mem[cof_addr];
  end

  // multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a     = cof_rd_r;
    mul_b     = mat_rd_r;
    case (state_r)
      S_TD: begin
        mul_start = 1'b1;
        mul_a     = {{(W-EL_W){el_a_r[EL_W-1]}}, el_a_r};
        mul_b     = el_b_r;
      end
      S_TM1: begin
        mul_start = mul_done;
        mul_a     = mul_p;
        mul_b     = el_c_r;
      end
      S_DB: mul_start = 1'b1;
      default: ;
    endcase
  end

  mi4_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // numerator is |cofactor| scaled by 2^(2*FRAC_BITS)
  assign cof_abs   = cof_rd_r[W-1] ? (~cof_rd_r + 1'b1) : cof_rd_r;
  assign div_num   = cof_abs << (2 * FRAC_BITS);
  assign div_start = (state_r == S_VB) && !sing_r;

  mi4_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dmag_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // quotient sign and saturation
  always_comb begin
    q_neg = (div_q != '0) && (num_neg_r != dneg_r);
    q_lim = q_neg ? EL_MIN : EL_MAX;
    q_sat = (div_q[W-1:EL_W] != '0) || (div_q[EL_W-1:0] > q_lim);
    if (q_sat) begin
      q_val = q_lim;
    end else if (q_neg) begin
      q_val = ~div_q[EL_W-1:0] + 1'b1;
    end else begin
      q_val = div_q[EL_W-1:0];
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      cof_idx_r  <= '0;
      perm_r     <= '0;
      dj_r       <= '0;
      vk_r       <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            load_cnt_r <= load_cnt_r + 4'd1;
            if (load_cnt_r == 4'd15) begin
              cof_idx_r <= '0;
              perm_r    <= '0;
              state_r   <= S_TA;
            end
          end
        end
        S_TA:  state_r <= S_TB;
        S_TB:  state_r <= S_TC;
        S_TC:  state_r <= S_TD;
        S_TD:  state_r <= S_TM1;
        S_TM1: if (mul_done) state_r <= S_TM2;
        S_TM2: begin
          if (mul_done) begin
            if (perm_r == PERM_LAST) begin
              perm_r <= '0;
              if (cof_idx_r == 4'd15) begin
                dj_r    <= '0;
                state_r <= S_DA;
              end else begin
                cof_idx_r <= cof_idx_r + 4'd1;
                state_r   <= S_TA;
              end
            end else begin
              perm_r  <= perm_r + 3'd1;
              state_r <= S_TA;
            end
          end
        end
        S_DA: state_r <= S_DB;
        S_DB: state_r <= S_DM;
        S_DM: begin
          if (mul_done) begin
            dj_r    <= dj_r + 2'd1;
            state_r <= (dj_r == 2'd3) ? S_DCHK : S_DA;
          end
        end
        S_DCHK: begin
          vk_r    <= '0;
          state_r <= S_VA;
        end
        S_VA: state_r <= S_VB;
        S_VB: state_r <= sing_r ? S_VOUT : S_VDIV;
        S_VDIV: if (div_done) state_r <= S_VOUT;
        S_VOUT: begin
          if (out_chan.ready) begin
            vk_r    <= vk_r + 4'd1;
            state_r <= (vk_r == 4'd15) ? S_LOAD : S_VA;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: acc_r <= '0;
      S_TB:   el_a_r <= mat_rd_r;
      S_TC:   el_b_r <= mat_rd_r;
      S_TD: begin
        el_c_r <= mat_rd_r;
        if (cof_idx_r == 4'd15 && perm_r == PERM_LAST) det_r <= '0;
      end
      S_TM2: if (mul_done) acc_r <= (perm_r == PERM_LAST) ? '0 : term_sum;
      S_DM:  if (mul_done) det_r <= det_r + mul_p;
      S_DCHK: begin
        sing_r <= (det_r == '0);
        dneg_r <= det_r[W-1];
        dmag_r <= det_r[W-1] ? (~det_r + 1'b1) : det_r;
      end
      S_VB: begin
        num_neg_r <= cof_rd_r[W-1];
        if (sing_r) begin
          out_val_r <= EL_MAX;
          out_sat_r <= 1'b1;
        end
      end
      S_VDIV: begin
        if (div_done) begin
          out_val_r <= q_val;
          out_sat_r <= q_sat;
        end
      end
      default: ;
    endcase
  end

  // channel outputs
  assign in_chan.ready            = (state_r == S_LOAD);
  assign out_chan.valid           = (state_r == S_VOUT);
  assign out_chan.inverse_element = out_val_r;
  assign out_chan.element_index   = vk_r;
  assign out_chan.last            = (vk_r == 4'd15);
  assign out_chan.singular        = sing_r;
  assign out_chan.saturated       = out_sat_r;

endmodule
